### design/resistive_touch_position_tracker_macros.svh
// ============================================================================
// Touch tracker assertion macros
// Immediate-implication and next-cycle-implication checks, compiled away
// when SYNTH is defined.
// ============================================================================
`ifndef RESISTIVE_TOUCH_POSITION_TRACKER_MACROS_SVH
`define RESISTIVE_TOUCH_POSITION_TRACKER_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define RTPT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define RTPT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RTPT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define RTPT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

### design/rtpt_pkg.sv
// ============================================================================
// Touch tracker package
// Field widths, command, status and phase codes, register map and the
// structs passed between the tracker modules.
// ============================================================================
package rtpt_pkg;

    // field widths
    localparam int ADC_W  = 12;
    localparam int CMD_W  = 2;
    localparam int STAT_W = 3;
    localparam int COL_W  = 8;
    localparam int ROW_W  = 9;
    localparam int PH_W   = 2;

    // command codes
    localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DOWN   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_UP     = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
    localparam logic [STAT_W-1:0] ST_NOINIT  = 3'd1;
    localparam logic [STAT_W-1:0] ST_NOTOUCH = 3'd2;
    localparam logic [STAT_W-1:0] ST_OUTSIDE = 3'd3;
    localparam logic [STAT_W-1:0] ST_EVENT   = 3'd4;

    // touch phase codes
    localparam logic [PH_W-1:0] PH_IDLE = 2'd0;
    localparam logic [PH_W-1:0] PH_DOWN = 2'd1;
    localparam logic [PH_W-1:0] PH_MOVE = 2'd2;
    localparam logic [PH_W-1:0] PH_UP   = 2'd3;

    // register map
    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_ENABLED = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_X_MIN   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_X_MAX   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_Y_MIN   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_Y_MAX   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_OUTSIDE = 3'd5;

    // register reset values
    localparam logic [ADC_W-1:0] RST_X_MIN   = 12'd500;
    localparam logic [ADC_W-1:0] RST_X_MAX   = 12'd3600;
    localparam logic [ADC_W-1:0] RST_Y_MIN   = 12'd300;
    localparam logic [ADC_W-1:0] RST_Y_MAX   = 12'd3780;
    localparam logic [ADC_W-1:0] RST_OUTSIDE = 12'd3995;

    // command queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic             enabled;
        logic [ADC_W-1:0] x_cal_min;
        logic [ADC_W-1:0] x_cal_max;
        logic [ADC_W-1:0] y_cal_min;
        logic [ADC_W-1:0] y_cal_max;
        logic [ADC_W-1:0] outside_limit;
    } t_cfg;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [ADC_W-1:0] adc_x;
        logic [ADC_W-1:0] adc_y;
    } t_item;

endpackage

### design/rtpt_if.sv
// ============================================================================
// Touch tracker channels
// Valid/ready channels for command items in and position reports out.
// ============================================================================
interface rtpt_in_if;
    logic                             valid;
    logic                             ready;
    logic [rtpt_pkg::CMD_W-1:0]       cmd;
    logic [rtpt_pkg::ADC_W-1:0]       adc_x;
    logic [rtpt_pkg::ADC_W-1:0]       adc_y;

    modport source (output valid, cmd, adc_x, adc_y, input ready);
    modport sink   (input valid, cmd, adc_x, adc_y, output ready);
endinterface

interface rtpt_out_if;
    logic                             valid;
    logic                             ready;
    logic [rtpt_pkg::STAT_W-1:0]      status;
    logic [rtpt_pkg::COL_W-1:0]       pos_x;
    logic [rtpt_pkg::ROW_W-1:0]       pos_y;
    logic [rtpt_pkg::PH_W-1:0]        touch_phase;

    modport source (output valid, status, pos_x, pos_y, touch_phase, input ready);
    modport sink   (input valid, status, pos_x, pos_y, touch_phase, output ready);
endinterface

### design/rtpt_regs.sv
// ============================================================================
// Touch tracker register file
// APB-style calibration and enable registers, zero-wait writes and reads.
// ============================================================================
module rtpt_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_psel,
    input  logic                            i_penable,
    input  logic                            i_pwrite,
    input  logic [rtpt_pkg::PADDR_W-1:0]    i_paddr,
    input  logic [rtpt_pkg::PDATA_W-1:0]    i_pwdata,
    output logic [rtpt_pkg::PDATA_W-1:0]    o_prdata,
    output logic                            o_pready,
    output rtpt_pkg::t_cfg                  o_cfg
);
    localparam int ADC_W   = rtpt_pkg::ADC_W;
    localparam int PDATA_W = rtpt_pkg::PDATA_W;

    rtpt_pkg::t_cfg                    r_cfg;
    logic [rtpt_pkg::REG_IDX_W-1:0]    w_idx;
    logic                              w_wr;

    assign w_idx    = i_paddr[rtpt_pkg::PADDR_W-1:2];
    assign w_wr     = i_psel && i_penable && i_pwrite;
    assign o_pready = 1'b1;
    assign o_cfg    = r_cfg;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enabled       <= 1'b0;
            r_cfg.x_cal_min     <= rtpt_pkg::RST_X_MIN;
            r_cfg.x_cal_max     <= rtpt_pkg::RST_X_MAX;
            r_cfg.y_cal_min     <= rtpt_pkg::RST_Y_MIN;
            r_cfg.y_cal_max     <= rtpt_pkg::RST_Y_MAX;
            r_cfg.outside_limit <= rtpt_pkg::RST_OUTSIDE;
        end else if (w_wr) begin
            unique case (w_idx)
                rtpt_pkg::REG_ENABLED: r_cfg.enabled       <= i_pwdata[0];
                rtpt_pkg::REG_X_MIN:   r_cfg.x_cal_min     <= i_pwdata[ADC_W-1:0];
                rtpt_pkg::REG_X_MAX:   r_cfg.x_cal_max     <= i_pwdata[ADC_W-1:0];
                rtpt_pkg::REG_Y_MIN:   r_cfg.y_cal_min     <= i_pwdata[ADC_W-1:0];
                rtpt_pkg::REG_Y_MAX:   r_cfg.y_cal_max     <= i_pwdata[ADC_W-1:0];
                rtpt_pkg::REG_OUTSIDE: r_cfg.outside_limit <= i_pwdata[ADC_W-1:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (w_idx)
            rtpt_pkg::REG_ENABLED: o_prdata = PDATA_W'(r_cfg.enabled);
            rtpt_pkg::REG_X_MIN:   o_prdata = PDATA_W'(r_cfg.x_cal_min);
            rtpt_pkg::REG_X_MAX:   o_prdata = PDATA_W'(r_cfg.x_cal_max);
            rtpt_pkg::REG_Y_MIN:   o_prdata = PDATA_W'(r_cfg.y_cal_min);
            rtpt_pkg::REG_Y_MAX:   o_prdata = PDATA_W'(r_cfg.y_cal_max);
            rtpt_pkg::REG_OUTSIDE: o_prdata = PDATA_W'(r_cfg.outside_limit);
            default:               o_prdata = '0;
        endcase
    end

endmodule

### design/rtpt_front.sv
// ============================================================================
// Touch tracker front end
// Takes command items, drops the unused command code and queues the rest
// for the back end in a two-entry queue.
// ============================================================================
`include "resistive_touch_position_tracker_macros.svh"

module rtpt_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    rtpt_in_if.sink         i_in,
    output rtpt_pkg::t_item o_head,
    output logic            o_head_valid,
    input  logic            i_pop
);
    localparam int Q_DEPTH = rtpt_pkg::Q_DEPTH;
    localparam int Q_PTR_W = rtpt_pkg::Q_PTR_W;
    localparam int Q_CNT_W = rtpt_pkg::Q_CNT_W;

    rtpt_pkg::t_item        r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]     r_wr_ptr;
    logic [Q_PTR_W-1:0]     r_rd_ptr;
    logic [Q_CNT_W-1:0]     r_count;
    logic                   w_push;

    // unused command code is taken and dropped here
    assign i_in.ready   = (r_count != Q_CNT_W'(Q_DEPTH));
    assign w_push       = i_in.valid && i_in.ready && (i_in.cmd != rtpt_pkg::CMD_NONE);
    assign o_head       = r_mem[r_rd_ptr];
    assign o_head_valid = (r_count != '0);

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= '{cmd: i_in.cmd, adc_x: i_in.adc_x, adc_y: i_in.adc_y};
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({w_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    `RTPT_ASSERT_IMP(a_pop_not_empty, i_clk, i_rst_n, i_pop, r_count != '0, "pop from empty queue")
    `RTPT_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= Q_CNT_W'(Q_DEPTH), "queue overfilled")

endmodule

### design/rtpt_back.sv
// ============================================================================
// Touch tracker back end
// Executes queued commands: touch phase tracking, sample rejection, and
// clamp, scale and serial divide of both coordinates; holds the result
// register of the output channel.
// ============================================================================
`include "resistive_touch_position_tracker_macros.svh"

module rtpt_back #(
    parameter int SCREEN_WIDTH  = 240,
    parameter int SCREEN_HEIGHT = 320
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  rtpt_pkg::t_cfg  i_cfg,
    input  rtpt_pkg::t_item i_head,
    input  logic            i_head_valid,
    output logic            o_pop,
    rtpt_out_if.source      o_out
);
    localparam int ADC_W    = rtpt_pkg::ADC_W;
    localparam int COL_W    = rtpt_pkg::COL_W;
    localparam int ROW_W    = rtpt_pkg::ROW_W;
    localparam int STAT_W   = rtpt_pkg::STAT_W;
    localparam int PH_W     = rtpt_pkg::PH_W;
    localparam int SIZE_MAX = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
    // quotient never exceeds the screen size, so this many divide steps
    localparam int SIZE_W   = $clog2(SIZE_MAX + 1);
    localparam int PROD_W   = ADC_W + SIZE_W;
    localparam int CNT_W    = $clog2(SIZE_W);
    localparam logic [SIZE_W-1:0] SIZE_X = SIZE_W'(SCREEN_WIDTH);
    localparam logic [SIZE_W-1:0] SIZE_Y = SIZE_W'(SCREEN_HEIGHT);
    localparam logic [CNT_W-1:0]  CNT_LAST = CNT_W'(SIZE_W - 1);

    typedef enum logic [2:0] {S_IDLE, S_PREP, S_MUL, S_DIV, S_EMIT} t_state;

    // sequencer and tracking state
    t_state              r_state;
    logic                r_axis;
    logic [CNT_W-1:0]    r_cnt;
    logic [PH_W-1:0]     r_phase;
    logic [COL_W-1:0]    r_last_col;
    logic [ROW_W-1:0]    r_last_row;
    logic                r_has_point;
    // datapath
    logic [ADC_W-1:0]    r_ax;
    logic [ADC_W-1:0]    r_ay;
    logic [ADC_W-1:0]    r_diff;
    logic [ADC_W-1:0]    r_div;
    logic [ADC_W-1:0]    r_rem;
    logic [SIZE_W-1:0]   r_quo;
    logic [SIZE_W-1:0]   r_qx;
    logic [SIZE_W-1:0]   r_qy;
    // result register
    logic                r_out_valid;
    logic [STAT_W-1:0]   r_out_status;
    logic [COL_W-1:0]    r_out_x;
    logic [ROW_W-1:0]    r_out_y;
    logic [PH_W-1:0]     r_out_phase;

    logic                w_out_free;
    logic                w_compute;
    logic                w_imm;
    logic                w_drop;
    logic [STAT_W-1:0]   w_status;
    logic [PH_W-1:0]     w_phase_rep;
    logic [PH_W-1:0]     w_phase_nxt;
    logic                w_imm_load;
    logic                w_emit_load;
    logic                w_load;
    logic [ADC_W-1:0]    w_raw;
    logic [ADC_W-1:0]    w_lo;
    logic [ADC_W-1:0]    w_hi;
    logic [ADC_W-1:0]    w_clamp;
    logic                w_empty;
    logic [SIZE_W-1:0]   w_size;
    logic [PROD_W-1:0]   w_prod;
    logic [ADC_W:0]      w_trial;
    logic [ADC_W-1:0]    w_sub;
    logic                w_ge;
    logic [ADC_W-1:0]    w_rem_nxt;
    logic [SIZE_W-1:0]   w_quo_nxt;
    logic                w_axis_fin;
    logic [SIZE_W-1:0]   w_axis_q;

    assign w_out_free = !r_out_valid || o_out.ready;

    // classify the head command against the current touch state
    always_comb begin
        w_compute   = 1'b0;
        w_imm       = 1'b0;
        w_drop      = 1'b0;
        w_status    = rtpt_pkg::ST_EVENT;
        w_phase_rep = r_phase;
        w_phase_nxt = r_phase;
        unique case (i_head.cmd)
            rtpt_pkg::CMD_SAMPLE: begin
                priority if (!i_cfg.enabled) begin
                    w_imm    = 1'b1;
                    w_status = rtpt_pkg::ST_NOINIT;
                end else if (r_phase == rtpt_pkg::PH_IDLE) begin
                    w_imm    = 1'b1;
                    w_status = rtpt_pkg::ST_NOTOUCH;
                end else if (i_head.adc_x > i_cfg.outside_limit) begin
                    w_imm    = 1'b1;
                    w_status = rtpt_pkg::ST_OUTSIDE;
                end else begin
                    w_compute = 1'b1;
                end
            end
            rtpt_pkg::CMD_DOWN: begin
                w_imm = 1'b1;
                if (r_phase == rtpt_pkg::PH_IDLE) begin
                    w_phase_nxt = rtpt_pkg::PH_DOWN;
                end
                w_phase_rep = w_phase_nxt;
            end
            rtpt_pkg::CMD_UP: begin
                w_imm       = 1'b1;
                w_phase_nxt = rtpt_pkg::PH_IDLE;
                w_phase_rep = r_has_point ? rtpt_pkg::PH_UP : rtpt_pkg::PH_IDLE;
            end
            default: begin
                w_drop = 1'b1;
            end
        endcase
    end

    assign w_imm_load  = (r_state == S_IDLE) && i_head_valid && w_imm && w_out_free;
    assign w_emit_load = (r_state == S_EMIT) && w_out_free;
    assign w_load      = w_imm_load || w_emit_load;
    assign o_pop       = (r_state == S_IDLE) && i_head_valid
                         && (w_compute || w_drop || (w_imm && w_out_free));

    // clamp to the calibration window of the current axis
    always_comb begin
        w_raw   = r_axis ? r_ay : r_ax;
        w_lo    = r_axis ? i_cfg.y_cal_min : i_cfg.x_cal_min;
        w_hi    = r_axis ? i_cfg.y_cal_max : i_cfg.x_cal_max;
        w_empty = (w_hi <= w_lo);
        priority if (w_raw < w_lo) begin
            w_clamp = w_lo;
        end else if (w_raw > w_hi) begin
            w_clamp = w_hi;
        end else begin
            w_clamp = w_raw;
        end
    end

    // scale by screen size
    assign w_size = r_axis ? SIZE_Y : SIZE_X;
    assign w_prod = PROD_W'(r_diff) * PROD_W'(w_size);

    // one restoring divide step; remainder stays below the divisor
    assign w_trial   = {r_rem, r_quo[SIZE_W-1]};
    assign w_ge      = (w_trial >= {1'b0, r_div});
    assign w_sub     = w_trial[ADC_W-1:0] - r_div;
    assign w_rem_nxt = w_ge ? w_sub : w_trial[ADC_W-1:0];
    assign w_quo_nxt = {r_quo[SIZE_W-2:0], w_ge};

    // axis finished: empty window or last divide step
    always_comb begin
        w_axis_fin = 1'b0;
        w_axis_q   = '0;
        if ((r_state == S_PREP) && w_empty) begin
            w_axis_fin = 1'b1;
        end else if ((r_state == S_DIV) && (r_cnt == CNT_LAST)) begin
            w_axis_fin = 1'b1;
            w_axis_q   = w_quo_nxt;
        end
    end

    // sequencer, tracking state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_axis      <= 1'b0;
            r_cnt       <= '0;
            r_phase     <= rtpt_pkg::PH_IDLE;
            r_last_col  <= '0;
            r_last_row  <= '0;
            r_has_point <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
                if (w_emit_load) begin
                    r_out_status <= rtpt_pkg::ST_OK;
                    r_out_x      <= COL_W'(r_qx);
                    r_out_y      <= ROW_W'(r_qy);
                    r_out_phase  <= r_phase;
                end else begin
                    r_out_status <= w_status;
                    r_out_x      <= r_last_col;
                    r_out_y      <= r_last_row;
                    r_out_phase  <= w_phase_rep;
                end
            end else if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        if (w_compute) begin
                            r_ax    <= i_head.adc_x;
                            r_ay    <= i_head.adc_y;
                            r_axis  <= 1'b0;
                            r_state <= S_PREP;
                        end else begin
                            r_phase <= w_phase_nxt;
                        end
                    end
                end
                S_PREP: begin
                    r_diff <= w_hi - w_clamp;
                    r_div  <= w_hi - w_lo;
                    // empty window finishes the axis below
                    if (!w_empty) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_rem   <= w_prod[PROD_W-1:SIZE_W];
                    r_quo   <= w_prod[SIZE_W-1:0];
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem <= w_rem_nxt;
                    r_quo <= w_quo_nxt;
                    r_cnt <= r_cnt + 1'b1;
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_last_col  <= COL_W'(r_qx);
                        r_last_row  <= ROW_W'(r_qy);
                        r_has_point <= 1'b1;
                        r_phase     <= rtpt_pkg::PH_MOVE;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            // store the coordinate and move on to the next axis or the report
            if (w_axis_fin) begin
                if (!r_axis) begin
                    r_qx    <= w_axis_q;
                    r_axis  <= 1'b1;
                    r_state <= S_PREP;
                end else begin
                    r_qy    <= w_axis_q;
                    r_state <= S_EMIT;
                end
            end
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_out_status;
    assign o_out.pos_x       = r_out_x;
    assign o_out.pos_y       = r_out_y;
    assign o_out.touch_phase = r_out_phase;

    `RTPT_ASSERT_IMP(a_load_free, i_clk, i_rst_n, w_load, w_out_free, "result overwritten")
    `RTPT_ASSERT_IMP(a_rem_below_div, i_clk, i_rst_n, r_state == S_DIV,
                     r_rem < r_div, "divider remainder out of range")
    `RTPT_ASSERT_IMP(a_quo_range, i_clk, i_rst_n, r_state == S_EMIT,
                     (r_qx <= SIZE_X) && (r_qy <= SIZE_Y), "scaled position beyond screen")
    `RTPT_ASSERT_NXT(a_sample_moves, i_clk, i_rst_n, w_emit_load,
                     (r_phase == rtpt_pkg::PH_MOVE) && r_has_point,
                     "sample report did not update phase")

endmodule

### design/resistive_touch_position_tracker.sv
// ============================================================================
// Resistive touch position tracker
// Follows a pen through down/up events and raw X/Y samples, reporting a
// status, the touch phase and the calibrated pixel position per command.
// ============================================================================
//  Channel   Dir  Handshake              Payload
//  i_in      in   valid/ready            cmd, adc_x, adc_y
//  o_out     out  valid/ready            status, pos_x, pos_y, touch_phase
//  APB       in   psel/penable/pready    paddr, pwdata, prdata
//
//  Pen events and rejected samples are answered from the back end's idle state;
//  accepted samples clamp, scale and divide X, then Y, in the shared
//  one-bit-per-cycle divider over the bits of the larger screen size.
//  A two-entry queue keeps taking commands while the back end works,
//  until it is full; a held result stalls only the back end. Reset is
//  synchronous, no clearing pass. Command code 3 is taken and gives no result.
// ============================================================================
module resistive_touch_position_tracker #(
    parameter int SCREEN_WIDTH  = 240,
    parameter int SCREEN_HEIGHT = 320
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    rtpt_in_if.sink                         i_in,
    rtpt_out_if.source                      o_out,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rtpt_pkg::PADDR_W-1:0]    paddr,
    input  logic [rtpt_pkg::PDATA_W-1:0]    pwdata,
    output logic [rtpt_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready
);
    rtpt_pkg::t_cfg  w_cfg;
    rtpt_pkg::t_item w_head;
    logic            w_head_valid;
    logic            w_pop;

    // configuration registers
    rtpt_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready),
        .o_cfg     (w_cfg)
    );

    // command intake and queue
    rtpt_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_head       (w_head),
        .o_head_valid (w_head_valid),
        .i_pop        (w_pop)
    );

    // command execution and result register
    rtpt_back #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_head       (w_head),
        .i_head_valid (w_head_valid),
        .o_pop        (w_pop),
        .o_out        (o_out)
    );

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// ============================================================================
// Touch position tracker testbench
// Streams pen events and raw X/Y samples through the tracker under several
// calibration settings and idle patterns on both channels. Each transfer
// into the block is run through a local tracker model, and every report is
// checked field by field against the oldest predicted one.
// ============================================================================
module tb;
    import rtpt_pkg::*;

    localparam int SCR_W        = 240;
    localparam int SCR_H        = 320;
    localparam int SETTLE_CYCLES = 40;   // back end plus queue, with margin
    localparam int MAX_REPORTED = 10;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [COL_W-1:0]  pos_x;
        logic [ROW_W-1:0]  pos_y;
        logic [PH_W-1:0]   touch_phase;
    } report_t;

    logic i_clk;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    rtpt_in_if  in_ch ();
    rtpt_out_if out_ch ();

    resistive_touch_position_tracker #(
        .SCREEN_WIDTH  (SCR_W),
        .SCREEN_HEIGHT (SCR_H)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // commands waiting to be sent, reports waiting to come back
    t_item   cmd_queue[$];
    report_t pending_reports[$];
    t_item   cur_cmd;

    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned err_count;

    // local copy of the tracker registers and state
    t_cfg            cal;
    logic [PH_W-1:0]  trk_phase;
    logic [COL_W-1:0] last_col;
    logic [ROW_W-1:0] last_row;
    logic             seen_point;

    // clock and known input levels from time zero
    initial begin
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        in_ch.valid   = 1'b0;
        in_ch.cmd     = CMD_SAMPLE;
        in_ch.adc_x   = '0;
        in_ch.adc_y   = '0;
        out_ch.ready  = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // raw coordinate to pixels, clamped to the window, inverted
    function automatic int unsigned to_pixels(int unsigned raw, int unsigned lo,
                                              int unsigned hi, int unsigned size);
        int unsigned c;
        if (hi <= lo) return 0;
        c = raw;
        if (c < lo) c = lo;
        if (c > hi) c = hi;
        return ((hi - c) * size) / (hi - lo);
    endfunction

    // advance the tracker model by one command, queue its report
    function automatic void track_pen(t_item it);
        report_t     r;
        int unsigned col;
        int unsigned row;
        r = '{ST_EVENT, last_col, last_row, trk_phase};
        case (it.cmd)
            CMD_SAMPLE: begin
                if (!cal.enabled) begin
                    r.status = ST_NOINIT;
                end else if (trk_phase == PH_IDLE) begin
                    r.status = ST_NOTOUCH;
                end else if (it.adc_x > cal.outside_limit) begin
                    r.status = ST_OUTSIDE;
                end else begin
                    col = to_pixels(it.adc_x, cal.x_cal_min, cal.x_cal_max, SCR_W);
                    row = to_pixels(it.adc_y, cal.y_cal_min, cal.y_cal_max, SCR_H);
                    r = '{ST_OK, col[COL_W-1:0], row[ROW_W-1:0], trk_phase};
                    last_col   = col[COL_W-1:0];
                    last_row   = row[ROW_W-1:0];
                    seen_point = 1'b1;
                    trk_phase  = PH_MOVE;
                end
                pending_reports.push_back(r);
            end
            CMD_DOWN: begin
                if (trk_phase == PH_IDLE) trk_phase = PH_DOWN;
                r.touch_phase = trk_phase;
                pending_reports.push_back(r);
            end
            CMD_UP: begin
                trk_phase     = PH_IDLE;
                r.touch_phase = seen_point ? PH_UP : PH_IDLE;
                pending_reports.push_back(r);
            end
            default: ; // unused code: taken silently
        endcase
    endfunction

    function automatic void add_cmd(logic [CMD_W-1:0] c, logic [ADC_W-1:0] x,
                                    logic [ADC_W-1:0] y);
        t_item it;
        it.cmd   = c;
        it.adc_x = x;
        it.adc_y = y;
        cmd_queue.push_back(it);
    endfunction

    // raw value biased toward the rails
    function automatic logic [ADC_W-1:0] rand_adc();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return ADC_W'($urandom_range(0, 4095));
        endcase
    endfunction

    // pen strokes with random content, plus some stray commands
    function automatic void add_strokes(int n);
        int sent;
        int len;
        sent = 0;
        while (sent < n) begin
            if ($urandom_range(0, 99) < 85) begin
                add_cmd(CMD_DOWN, rand_adc(), rand_adc());
                len = $urandom_range(1, 8);
                for (int k = 0; k < len; k++) begin
                    if ($urandom_range(0, 19) == 0) add_cmd(CMD_DOWN, rand_adc(), rand_adc());
                    add_cmd(CMD_SAMPLE, rand_adc(), rand_adc());
                end
                add_cmd(CMD_UP, rand_adc(), rand_adc());
                sent += len + 2;
            end else begin
                add_cmd(CMD_W'($urandom_range(0, 3)), rand_adc(), rand_adc());
                sent++;
            end
        end
    endfunction

    // input driver: one transfer per handshake, random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) track_pen(cur_cmd);
            if (!in_ch.valid || in_ch.ready) begin
                if (cmd_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    cur_cmd = cmd_queue.pop_front();
                    in_ch.valid <= 1'b1;
                    in_ch.cmd   <= cur_cmd.cmd;
                    in_ch.adc_x <= cur_cmd.adc_x;
                    in_ch.adc_y <= cur_cmd.adc_y;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // report monitor: compare against the oldest prediction
    always @(posedge i_clk) begin
        report_t want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (pending_reports.size() == 0) begin
                    err_count++;
                    if (err_count <= MAX_REPORTED)
                        $display("%0t: unexpected report st=%0d x=%0d y=%0d ph=%0d", $realtime,
                                 out_ch.status, out_ch.pos_x, out_ch.pos_y, out_ch.touch_phase);
                end else begin
                    want = pending_reports.pop_front();
                    if (out_ch.status !== want.status || out_ch.pos_x !== want.pos_x ||
                        out_ch.pos_y !== want.pos_y ||
                        out_ch.touch_phase !== want.touch_phase) begin
                        err_count++;
                        if (err_count <= MAX_REPORTED)
                            $display("%0t: report mismatch exp st=%0d x=%0d y=%0d ph=%0d, got st=%0d x=%0d y=%0d ph=%0d",
                                     $realtime, want.status, want.pos_x, want.pos_y,
                                     want.touch_phase, out_ch.status, out_ch.pos_x,
                                     out_ch.pos_y, out_ch.touch_phase);
                    end
                end
            end
            out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // APB write: setup cycle, then access until pready
    task automatic reg_write(logic [REG_IDX_W-1:0] idx, logic [PDATA_W-1:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_ENABLED: cal.enabled       = val[0];
            REG_X_MIN:   cal.x_cal_min     = val[ADC_W-1:0];
            REG_X_MAX:   cal.x_cal_max     = val[ADC_W-1:0];
            REG_Y_MIN:   cal.y_cal_min     = val[ADC_W-1:0];
            REG_Y_MAX:   cal.y_cal_max     = val[ADC_W-1:0];
            REG_OUTSIDE: cal.outside_limit = val[ADC_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_cal(logic en, int unsigned xmin, int unsigned xmax,
                           int unsigned ymin, int unsigned ymax, int unsigned outl);
        reg_write(REG_ENABLED, PDATA_W'(en));
        reg_write(REG_X_MIN, PDATA_W'(xmin));
        reg_write(REG_X_MAX, PDATA_W'(xmax));
        reg_write(REG_Y_MIN, PDATA_W'(ymin));
        reg_write(REG_Y_MAX, PDATA_W'(ymax));
        reg_write(REG_OUTSIDE, PDATA_W'(outl));
    endtask

    // hold until every command is sent and every report is back
    task automatic wait_drained();
        @(negedge i_clk);
        while (cmd_queue.size() != 0 || in_ch.valid || pending_reports.size() != 0)
            @(negedge i_clk);
    endtask

    // drained, then room for a silent command still in the block
    task automatic wait_quiet();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // main sequence
    initial begin
        err_count      = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        cal = '{1'b0, RST_X_MIN, RST_X_MAX, RST_Y_MIN, RST_Y_MAX, RST_OUTSIDE};
        trk_phase  = PH_IDLE;
        last_col   = '0;
        last_row   = '0;
        seen_point = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // converters off: samples not initialized, events still tracked
        add_cmd(CMD_SAMPLE, 12'd2000, 12'd2000);
        add_cmd(CMD_UP, 12'd0, 12'd0);
        add_cmd(CMD_DOWN, 12'd0, 12'd0);
        add_cmd(CMD_SAMPLE, 12'd1000, 12'd1000);
        add_cmd(CMD_UP, 12'd0, 12'd0);
        wait_quiet();

        // reset calibration, enabled
        set_cal(1'b1, 500, 3600, 300, 3780, 3995);
        add_cmd(CMD_SAMPLE, 12'd2000, 12'd2000);   // no touch yet
        add_cmd(CMD_NONE, 12'd1234, 12'd321);
        add_cmd(CMD_DOWN, 12'd0, 12'd0);
        add_cmd(CMD_DOWN, 12'd0, 12'd0);           // already down
        add_cmd(CMD_SAMPLE, 12'd4095, 12'd0);      // outside the panel
        add_cmd(CMD_SAMPLE, 12'd3996, 12'd100);    // just above the limit
        add_cmd(CMD_SAMPLE, 12'd3995, 12'd4095);   // at the limit, clamp high
        add_cmd(CMD_SAMPLE, 12'd0, 12'd0);         // clamp low
        add_cmd(CMD_SAMPLE, 12'd500, 12'd300);
        add_cmd(CMD_SAMPLE, 12'd3600, 12'd3780);
        add_cmd(CMD_SAMPLE, 12'd2050, 12'd2040);
        add_cmd(CMD_NONE, 12'd4095, 12'd4095);
        add_cmd(CMD_DOWN, 12'd0, 12'd0);           // down while moving
        add_cmd(CMD_UP, 12'd0, 12'd0);
        add_cmd(CMD_SAMPLE, 12'd2000, 12'd2000);
        wait_quiet();

        // full X window, empty Y window, widest outside limit
        set_cal(1'b1, 0, 4095, 4095, 0, 4095);
        add_cmd(CMD_DOWN, 12'd0, 12'd0);
        add_cmd(CMD_SAMPLE, 12'd4095, 12'd4095);
        add_cmd(CMD_SAMPLE, 12'd0, 12'hAAA);
        add_cmd(CMD_SAMPLE, 12'h555, 12'h555);
        wait_quiet();

        // empty X window, outside limit at zero
        set_cal(1'b1, 2000, 2000, 0, 4095, 0);
        add_cmd(CMD_SAMPLE, 12'd0, 12'd4095);
        add_cmd(CMD_SAMPLE, 12'd1, 12'd0);
        add_cmd(CMD_UP, 12'd0, 12'd0);
        wait_quiet();

        // random strokes: one idle pattern per calibration setting
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct = 0;  recv_stall_pct = 0;
                    set_cal(1'b1, 500, 3600, 300, 3780, 3995);
                end
                1: begin
                    send_idle_pct = 77; recv_stall_pct = 0;
                    set_cal(1'b1, 0, 4095, 0, 4095, 4095);
                end
                2: begin
                    send_idle_pct = 0;  recv_stall_pct = 77;
                    set_cal(1'b1, $urandom_range(0, 4095), $urandom_range(0, 4095),
                            $urandom_range(0, 4095), $urandom_range(0, 4095),
                            $urandom_range(2048, 4095));
                end
                default: begin
                    send_idle_pct = 38; recv_stall_pct = 38;
                    set_cal(1'b1, 1000, 1001, 4094, 4095, $urandom_range(0, 4095));
                end
            endcase
            add_strokes(50);
            // sender holds until every report is back
            wait_drained();
            add_strokes(50);
            wait_quiet();
        end

        if (err_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // hang guard
    initial begin
        #3_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

### resistive_touch_position_tracker.f
+incdir+design
design/rtpt_pkg.sv
design/rtpt_if.sv
design/rtpt_regs.sv
design/rtpt_front.sv
design/rtpt_back.sv
design/resistive_touch_position_tracker.sv
tb/tb.sv
